>>> rtl/flacchk_pkg.sv
// ----------------------------------------------------------------------------
// flacchk_pkg
// Shared types, codes and constants of the FLAC codec header checker.
// ----------------------------------------------------------------------------
package flacchk_pkg;

  // blob shorter than this is rejected first; also the byte counter ceiling
  localparam logic [5:0]  SIZE_FLOOR  = 6'd42;
  localparam logic [23:0] INFO_LEN    = 24'd34;
  localparam logic [5:0]  INFO_BYTES  = 6'd34;
  localparam logic [6:0]  KIND_INFO   = 7'd0;
  localparam logic [6:0]  KIND_BANNED = 7'd127;

  // chain walk phases
  localparam logic [1:0] PH_MARK = 2'd0;
  localparam logic [1:0] PH_HDR  = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  // register indexes
  localparam logic [7:0] REG_MIN_BLOCK = 8'd0;
  localparam logic [7:0] REG_MAX_BLOCK = 8'd1;

  localparam logic [15:0] MIN_BLOCK_RESET = 16'd16;
  localparam logic [15:0] MAX_BLOCK_RESET = 16'hFFFF;

  // result codes, in check order
  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_SIZE      = 4'd1;
  localparam logic [3:0] ERR_MAGIC     = 4'd2;
  localparam logic [3:0] ERR_CHAIN     = 4'd3;
  localparam logic [3:0] ERR_NO_INFO   = 4'd4;
  localparam logic [3:0] ERR_BLOCK     = 4'd5;
  localparam logic [3:0] ERR_VARIABLE  = 4'd6;
  localparam logic [3:0] ERR_CHANNELS  = 4'd7;
  localparam logic [3:0] ERR_RATE      = 4'd8;
  localparam logic [3:0] ERR_DEPTH     = 4'd9;
  localparam logic [3:0] ERR_NO_TOTAL  = 4'd10;

  typedef struct packed {
    logic [5:0]  byte_total;
    logic        marker_good;
    logic [1:0]  walk_phase;
    logic [1:0]  header_pos;
    logic [6:0]  block_kind;
    logic [23:0] bytes_left;
    logic        last_seen;
    logic        info_seen;
    logic        chain_bad;
    logic [5:0]  info_pos;
    logic [15:0] min_size_seen;
    logic [15:0] max_size_seen;
    logic [63:0] packed_fields;
  } walk_state_t;

  localparam walk_state_t STATE_CLEAR = '{
    byte_total:    6'd0,
    marker_good:   1'b1,
    walk_phase:    PH_MARK,
    header_pos:    2'd0,
    block_kind:    7'd0,
    bytes_left:    24'd0,
    last_seen:     1'b0,
    info_seen:     1'b0,
    chain_bad:     1'b0,
    info_pos:      6'd0,
    min_size_seen: 16'd0,
    max_size_seen: 16'd0,
    packed_fields: 64'd0
  };

  typedef struct packed {
    logic [3:0]  error_code;
    logic [15:0] block_size;
    logic [19:0] sample_rate;
    logic [3:0]  channel_count;
    logic [5:0]  bits_per_sample;
    logic [35:0] total_samples;
  } result_t;

  // "fLaC"
  function automatic logic [7:0] marker_byte(input logic [1:0] pos);
    logic [7:0] m;
    case (pos)
      2'd0:    m = 8'h66;
      2'd1:    m = 8'h4C;
      2'd2:    m = 8'h61;
      default: m = 8'h43;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/flac_codec_header_checker_unit.sv
// ----------------------------------------------------------------------------
// flac_codec_header_checker_unit
// Byte-wise FLAC codec header checker: marker, metadata chain, STREAMINFO.
// ----------------------------------------------------------------------------
//
//  channel | handshake               | payload
//  --------+-------------------------+---------------------------------------
//  in      | in_valid_i / in_ready_o | byte_value_i, last_byte_i
//  out     | out_valid_o/out_ready_i | error_code_o, block_size_o, ...
//  cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item per cycle while no final byte stalls. An accepted byte is held in the
// input register, then updates the walk state; on the final byte the graded
// result is written to the output register and the walk state clears. Only a
// final byte can stall, when the output register still holds an untaken
// result; other bytes move on regardless of out_ready_i.
// Reset (rst_ni low, async) clears the walk state, empties both registers
// and restores min_block_size to 16 and max_block_size to 65535.
// cfg_ready_o is always high; unknown register indexes are dropped.
// ----------------------------------------------------------------------------
module flac_codec_header_checker_unit (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_value_i,
  input  logic        last_byte_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  error_code_o,
  output logic [15:0] block_size_o,
  output logic [19:0] sample_rate_o,
  output logic [3:0]  channel_count_o,
  output logic [5:0]  bits_per_sample_o,
  output logic [35:0] total_samples_o,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import flacchk_pkg::*;

  // configuration registers
  logic [15:0] min_block_q, max_block_q;

  // input register
  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        s1_last_q;
  logic        s1_fire;

  // walk state
  walk_state_t st_q, st_d, st_upd;

  // output register
  logic        out_valid_q;
  result_t     res_q, res_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_block_q <= MIN_BLOCK_RESET;
      max_block_q <= MAX_BLOCK_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MIN_BLOCK: min_block_q <= cfg_data_i;
        REG_MAX_BLOCK: max_block_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A final byte needs a free output slot; anything else always advances.
  assign s1_fire    = s1_valid_q && (!s1_last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q <= byte_value_i;
      s1_last_q <= last_byte_i;
    end
  end

  // Walk state after the byte in the input register.
  always_comb begin
    logic [23:0] hdr_len;
    logic [23:0] body_left;
    st_upd    = st_q;
    hdr_len   = {st_q.bytes_left[15:0], s1_byte_q};
    body_left = st_q.bytes_left - 24'd1;

    if (st_q.byte_total < SIZE_FLOOR) begin
      st_upd.byte_total = st_q.byte_total + 6'd1;
    end

    if (!st_q.chain_bad) begin
      case (st_q.walk_phase)
        PH_MARK: begin
          if (st_q.byte_total < 6'd4 &&
              s1_byte_q != marker_byte(st_q.byte_total[1:0])) begin
            st_upd.marker_good = 1'b0;
          end
          if (st_q.byte_total >= 6'd3) begin
            st_upd.walk_phase = PH_HDR;
          end
        end
        PH_HDR: begin
          if (st_q.header_pos == 2'd0) begin
            if (st_q.last_seen) begin
              // block after the one flagged last
              st_upd.chain_bad = 1'b1;
            end else begin
              st_upd.block_kind = s1_byte_q[6:0];
              st_upd.last_seen  = s1_byte_q[7];
              st_upd.bytes_left = '0;
              st_upd.header_pos = 2'd1;
            end
          end else begin
            st_upd.bytes_left = hdr_len;
            if (st_q.header_pos < 2'd3) begin
              st_upd.header_pos = st_q.header_pos + 2'd1;
            end else begin
              st_upd.header_pos = 2'd0;
              if (st_q.block_kind == KIND_BANNED) begin
                st_upd.chain_bad = 1'b1;
              end else if (st_q.block_kind == KIND_INFO &&
                           (st_q.info_seen || hdr_len != INFO_LEN)) begin
                // duplicate STREAMINFO or wrong length
                st_upd.chain_bad = 1'b1;
              end else begin
                if (st_q.block_kind == KIND_INFO) begin
                  st_upd.info_seen = 1'b1;
                  st_upd.info_pos  = '0;
                end
                st_upd.walk_phase = (hdr_len == 24'd0) ? PH_HDR : PH_BODY;
              end
            end
          end
        end
        PH_BODY: begin
          if (st_q.block_kind == KIND_INFO && st_q.info_pos < INFO_BYTES) begin
            if (st_q.info_pos < 6'd2) begin
              st_upd.min_size_seen = {st_q.min_size_seen[7:0], s1_byte_q};
            end else if (st_q.info_pos < 6'd4) begin
              st_upd.max_size_seen = {st_q.max_size_seen[7:0], s1_byte_q};
            end else if (st_q.info_pos >= 6'd10 && st_q.info_pos < 6'd18) begin
              st_upd.packed_fields = {st_q.packed_fields[55:0], s1_byte_q};
            end
            st_upd.info_pos = st_q.info_pos + 6'd1;
          end
          st_upd.bytes_left = body_left;
          if (body_left == 24'd0) begin
            st_upd.walk_phase = PH_HDR;
          end
        end
        default: begin
          st_upd.chain_bad = 1'b1;
        end
      endcase
    end
  end

  flacchk_judge u_judge (
    .state_i          (st_upd),
    .min_block_size_i (min_block_q),
    .max_block_size_i (max_block_q),
    .result_o         (res_d)
  );

  always_comb begin
    st_d = st_q;
    if (s1_fire) begin
      st_d = s1_last_q ? STATE_CLEAR : st_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= STATE_CLEAR;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_last_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign error_code_o      = res_q.error_code;
  assign block_size_o      = res_q.block_size;
  assign sample_rate_o     = res_q.sample_rate;
  assign channel_count_o   = res_q.channel_count;
  assign bits_per_sample_o = res_q.bits_per_sample;
  assign total_samples_o   = res_q.total_samples;

endmodule

>>> rtl/flacchk_judge.sv
// ----------------------------------------------------------------------------
// flacchk_judge
// Grades the walk state after the final byte and formats the result item.
// ----------------------------------------------------------------------------
module flacchk_judge (
  input  flacchk_pkg::walk_state_t state_i,
  input  logic [15:0]              min_block_size_i,
  input  logic [15:0]              max_block_size_i,
  output flacchk_pkg::result_t     result_o
);
  import flacchk_pkg::*;

  logic [63:0] p;
  logic [3:0]  err;

  assign p = state_i.packed_fields;

  always_comb begin
    if (state_i.byte_total < SIZE_FLOOR) begin
      err = ERR_SIZE;
    end else if (!state_i.marker_good) begin
      err = ERR_MAGIC;
    end else if (state_i.chain_bad || (state_i.walk_phase != PH_HDR) ||
                 (state_i.header_pos != 2'd0) || !state_i.last_seen) begin
      err = ERR_CHAIN;
    end else if (!state_i.info_seen) begin
      err = ERR_NO_INFO;
    end else if ((state_i.min_size_seen < min_block_size_i) ||
                 (state_i.max_size_seen < min_block_size_i) ||
                 (state_i.max_size_seen > max_block_size_i) ||
                 (state_i.min_size_seen > state_i.max_size_seen)) begin
      err = ERR_BLOCK;
    end else if (state_i.min_size_seen != state_i.max_size_seen) begin
      err = ERR_VARIABLE;
    end else if (p[43:41] > 3'd1) begin
      // channel field plus one must be 1 or 2
      err = ERR_CHANNELS;
    end else if (p[63:44] == 20'd0) begin
      err = ERR_RATE;
    end else if (p[40:36] < 5'd3) begin
      // depth field plus one under 4
      err = ERR_DEPTH;
    end else if (p[35:0] == 36'd0) begin
      err = ERR_NO_TOTAL;
    end else begin
      err = ERR_NONE;
    end
  end

  always_comb begin
    result_o            = '0;
    result_o.error_code = err;
    if (err == ERR_NONE) begin
      result_o.block_size      = state_i.max_size_seen;
      result_o.sample_rate     = p[63:44];
      result_o.channel_count   = {1'b0, p[43:41]} + 4'd1;
      result_o.bits_per_sample = {1'b0, p[40:36]} + 6'd1;
      result_o.total_samples   = p[35:0];
    end
  end

endmodule
